[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FDF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FDF_ASSERT(lbl, clk, rst, prop, msg)
`define FDF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/fdf_pkg.sv]
// ----------------------------------------------------------------------------
// FIR filter package
// Sizes, command codes and the queue entry shared by the filter modules.
// ----------------------------------------------------------------------------
package fdf_pkg;

   localparam int TAPS            = 32;
   localparam int TAP_IDX_W       = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int TAPCNT_W        = $clog2(TAPS + 1);
   localparam int SAMPLE_W        = 16;
   localparam int FRAC_W          = 15;
   localparam int CMD_W           = 2;
   localparam int COEF_IDX_W      = 5;
   localparam int TAP_COUNT_W     = 6;
   localparam int TAP_COUNT_RESET = 32;
   localparam int PROD_W          = 2 * SAMPLE_W;
   localparam int ACC_W           = PROD_W + TAP_IDX_W + 1;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_COEF   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [SAMPLE_W-1:0]   data;
      logic [COEF_IDX_W-1:0] idx;
   } queue_entry_type;

endpackage

[hw/rtl/fdf_front.sv]
// ----------------------------------------------------------------------------
// FIR filter front end
// Accepts request beats, drops commands with no effect and queues the rest.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdf_front
   import fdf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CMD_W-1:0]             req_command,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic [COEF_IDX_W-1:0]        req_coef_index,
   input  logic signed [SAMPLE_W-1:0]   req_coef_value,
   output logic                         q_valid,
   output queue_entry_type              q_entry,
   input  logic                         q_pop
);

   queue_entry_type    entry_ff [QUEUE_DEPTH];
   queue_entry_type    entry_in;
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               keep;
   logic               push;

   always_comb begin
      keep     = 1'b0;
      entry_in = '{cmd: req_command, data: req_sample_in, idx: req_coef_index};
      unique case (req_command)
         CMD_FILTER: begin
            keep = 1'b1;
         end
         CMD_COEF: begin
            keep          = (int'(req_coef_index) < TAPS);
            entry_in.data = req_coef_value;
         end
         CMD_CLEAR: begin
            keep = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   `FDF_ASSERT(a_queue_bound, clock, reset, (count_ff <= QCNT_W'(QUEUE_DEPTH)), "queue overfilled")

endmodule

[hw/rtl/fdf_back.sv]
// ----------------------------------------------------------------------------
// FIR filter back end
// Holds history and coefficients and runs one shared multiply-accumulate
// over the taps in use, then rounds, saturates and shifts the history.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fdf_back
   import fdf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic [TAPCNT_W-1:0]          taps_used,
   input  logic                         q_valid,
   input  queue_entry_type              q_entry,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_saturated
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_ROUND = 2'd3;

   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((1 <<< (SAMPLE_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);
   localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'(1 <<< (FRAC_W - 1));

   logic [1:0]                  state_ff, state_in;
   logic [TAP_IDX_W-1:0]        tap_ff, tap_in;
   logic signed [SAMPLE_W-1:0]  hist_ff [TAPS];
   logic signed [SAMPLE_W-1:0]  hist_in [TAPS];
   logic signed [SAMPLE_W-1:0]  coef_ff [TAPS];
   logic signed [SAMPLE_W-1:0]  coef_in [TAPS];
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic                        prod_vld_ff, prod_vld_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]  out_ff, out_in;
   logic                        sat_ff, sat_in;
   logic signed [ACC_W-1:0]     biased;
   logic signed [ACC_W-1:0]     shifted;
   logic                        last_tap;

   assign last_tap = (TAPCNT_W'(tap_ff) == taps_used - TAPCNT_W'(1));
   assign biased   = acc_ff + BIAS;
   assign shifted  = biased >>> FRAC_W;

   always_comb begin
      state_in     = state_ff;
      tap_in       = tap_ff;
      hist_in      = hist_ff;
      coef_in      = coef_ff;
      prod_in      = coef_ff[tap_ff] * hist_ff[tap_ff];
      prod_vld_in  = 1'b0;
      acc_in       = prod_vld_ff ? acc_ff + ACC_W'(prod_ff) : acc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_in       = out_ff;
      sat_in       = sat_ff;
      q_pop        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               unique case (q_entry.cmd)
                  CMD_FILTER: begin
                     hist_in[0] = q_entry.data;
                     tap_in     = '0;
                     acc_in     = '0;
                     state_in   = ST_RUN;
                  end
                  CMD_COEF: begin
                     for (int j = 0; j < TAPS; j++) begin
                        if (int'(q_entry.idx) == j) begin
                           coef_in[j] = q_entry.data;
                        end
                     end
                  end
                  CMD_CLEAR: begin
                     for (int j = 0; j < TAPS; j++) begin
                        hist_in[j] = '0;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            prod_vld_in = 1'b1;
            tap_in      = tap_ff + TAP_IDX_W'(1);
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               priority if (shifted > OUT_MAX) begin
                  out_in = OUT_MAX[SAMPLE_W-1:0];
                  sat_in = 1'b1;
               end else if (shifted < OUT_MIN) begin
                  out_in = OUT_MIN[SAMPLE_W-1:0];
                  sat_in = 1'b1;
               end else begin
                  out_in = shifted[SAMPLE_W-1:0];
                  sat_in = 1'b0;
               end
               for (int j = 1; j < TAPS; j++) begin
                  if (TAPCNT_W'(j) < taps_used) begin
                     hist_in[j] = hist_ff[j-1];
                  end
               end
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hist_ff      <= '{default: '0};
         coef_ff      <= '{default: '0};
      end else begin
         state_ff     <= state_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         hist_ff      <= hist_in;
         coef_ff      <= coef_in;
      end
   end

   always_ff @(posedge clock) begin
      tap_ff  <= tap_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      out_ff  <= out_in;
      sat_ff  <= sat_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = out_ff;
   assign rsp_saturated  = sat_ff;

   `FDF_ASSERT(a_tap_in_range, clock, reset, (state_ff == ST_RUN) |-> (TAPCNT_W'(tap_ff) < taps_used), "tap index beyond taps in use")
   `FDF_ASSERT(a_rsp_from_round, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_ROUND), "result appeared outside the round step")
   `FDF_ASSERT(a_prod_in_walk, clock, reset, prod_vld_ff |-> (state_ff == ST_RUN || state_ff == ST_DRAIN), "product pending outside the tap walk")

endmodule

[hw/rtl/fir_filter_direct_form.sv]
// ----------------------------------------------------------------------------
// Direct-form FIR filter
// Run-time tap count, Q1.15 samples and coefficients, rounded and saturated
// output, with a command queue in front of a shared multiply-accumulate.
//
//   channel   direction  handshake           beat carries
//   req_      in         valid / stall       command, sample, coefficient
//   rsp_      out        valid / stall       filtered sample, saturation flag
//   csr_      in         valid / ready       tap count
//
// A filter beat walks the taps in use in the back end, one tap per cycle
// through the single shared multiplier; other commands act when popped.
// The queue holds two beats, so requests are taken while the back end works.
// Synchronous reset zeroes history and coefficients and sets 32 taps in use.
// A stalled result holds the back end in its rounding step until taken.
// ----------------------------------------------------------------------------
module fir_filter_direct_form
   import fdf_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [CMD_W-1:0]             req_command,
   input  logic signed [SAMPLE_W-1:0]   req_sample_in,
   input  logic [COEF_IDX_W-1:0]        req_coef_index,
   input  logic signed [SAMPLE_W-1:0]   req_coef_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SAMPLE_W-1:0]   rsp_sample_out,
   output logic                         rsp_saturated,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [TAP_COUNT_W-1:0]       csr_tap_count
);

   logic [TAP_COUNT_W-1:0] tap_count_ff, tap_count_in;
   logic [TAPCNT_W-1:0]    taps_used;
   logic                   q_valid;
   queue_entry_type        q_entry;
   logic                   q_pop;

   assign csr_ready    = 1'b1;
   assign tap_count_in = csr_valid ? csr_tap_count : tap_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_W'(TAP_COUNT_RESET);
      end else begin
         tap_count_ff <= tap_count_in;
      end
   end

   always_comb begin
      priority if (tap_count_ff == '0) begin
         taps_used = TAPCNT_W'(1);
      end else if (int'(tap_count_ff) > TAPS) begin
         taps_used = TAPCNT_W'(TAPS);
      end else begin
         taps_used = TAPCNT_W'(tap_count_ff);
      end
   end

   fdf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop)
   );

   fdf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .taps_used      (taps_used),
      .q_valid        (q_valid),
      .q_entry        (q_entry),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .rsp_saturated  (rsp_saturated)
   );

endmodule
